@@ rtl/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the substitution-permutation block cipher.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int MaxRounds  = 16;
   localparam int NumBytes   = 16;
   localparam int NumNibbles = 32;

   localparam logic [2:0] OP_LOAD_SBOX = 3'd0;
   localparam logic [2:0] OP_LOAD_PBOX = 3'd1;
   localparam logic [2:0] OP_LOAD_KEY  = 3'd2;
   localparam logic [2:0] OP_ENCRYPT   = 3'd3;
   localparam logic [2:0] OP_DECRYPT   = 3'd4;

   localparam logic CSR_ROUND_COUNT = 1'b0;
   localparam logic CSR_PBOX_PERIOD = 1'b1;

   typedef logic [NumBytes-1:0][7:0]   byte_array_type;
   typedef logic [NumNibbles-1:0][4:0] nib_sel_type;

   // table write request shared by all byte lanes
   typedef struct packed {
      logic       sbox_we;
      logic [7:0] index;
      logic [7:0] value;
   } lane_wr_type;

endpackage

@@ rtl/sbc_ram.sv @@
// ----------------------------------------------------------------------------
// sbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/sbc_lane.sv @@
// ----------------------------------------------------------------------------
// sbc_lane
// One byte lane: forward and inverse s-box copies and this lane's key bytes.
// ----------------------------------------------------------------------------
module sbc_lane
   import sbc_pkg::*;
(
   input  logic        clock,
   input  lane_wr_type wr,
   input  logic        key_we,
   input  logic [7:0]  byte_addr,
   input  logic [3:0]  round_addr,
   input  logic        dec,
   output logic [7:0]  sub_byte,
   output logic [7:0]  key_byte
);

   logic [7:0] fwd_q;
   logic [7:0] inv_q;

   sbc_ram #(.Width(8), .Depth(256)) u_sbox (
      .clock (clock),
      .we    (wr.sbox_we),
      .waddr (wr.index),
      .wdata (wr.value),
      .raddr (byte_addr),
      .rdata (fwd_q)
   );

   sbc_ram #(.Width(8), .Depth(256)) u_inv_sbox (
      .clock (clock),
      .we    (wr.sbox_we),
      .waddr (wr.value),
      .wdata (wr.index),
      .raddr (byte_addr),
      .rdata (inv_q)
   );

   // lane k holds key bytes 16*r+k at address r
   sbc_ram #(.Width(8), .Depth(MaxRounds)) u_key (
      .clock (clock),
      .we    (key_we),
      .waddr (wr.index[7:4]),
      .wdata (wr.value),
      .raddr (round_addr),
      .rdata (key_byte)
   );

   assign sub_byte = dec ? inv_q : fwd_q;

endmodule

@@ rtl/sbc_mix.sv @@
// ----------------------------------------------------------------------------
// sbc_mix
// Merging stage: nibble permutation or chained xor diffusion and key mixing.
// ----------------------------------------------------------------------------
module sbc_mix
   import sbc_pkg::*;
(
   input  byte_array_type data,
   input  byte_array_type key,
   input  nib_sel_type    pbox,
   input  nib_sel_type    rev_pbox,
   input  logic           dec,
   input  logic           do_perm,
   input  logic           do_diff,
   output byte_array_type result
);

   byte_array_type          pre;
   byte_array_type          perm;
   byte_array_type          diff;
   byte_array_type          post;
   logic [NumNibbles-1:0][3:0] nin;
   logic [NumNibbles-1:0][3:0] nout;
   logic [7:0]              acc;
   logic [7:0]              total;
   logic [7:0]              t0;

   always_comb begin
      // decrypt mixes the key first, encrypt last
      pre = dec ? (data ^ key) : data;

      for (int k = 0; k < NumBytes; k++) begin
         nin[2*k]   = pre[k][7:4];
         nin[2*k+1] = pre[k][3:0];
      end
      for (int j = 0; j < NumNibbles; j++) begin
         nout[j] = dec ? nin[pbox[j]] : nin[rev_pbox[j]];
      end
      for (int k = 0; k < NumBytes; k++) begin
         perm[k] = {nout[2*k], nout[2*k+1]};
      end

      if (!dec) begin
         total = '0;
         for (int k = 0; k < NumBytes; k++) begin
            total = total ^ pre[k];
         end
         for (int k = 0; k < NumBytes; k++) begin
            acc = '0;
            for (int i = 0; i <= k; i++) begin
               acc = acc ^ pre[i];
            end
            diff[k] = acc;
         end
         diff[0] = pre[0] ^ total;
         t0 = '0;
      end else begin
         total = '0;
         acc   = '0;
         t0    = pre[0] ^ pre[NumBytes-1];
         diff[0] = t0;
         diff[1] = pre[1] ^ t0;
         for (int k = 2; k < NumBytes; k++) begin
            diff[k] = pre[k] ^ pre[k-1];
         end
      end

      if (do_perm) begin
         post = perm;
      end else if (do_diff) begin
         post = diff;
      end else begin
         post = pre;
      end

      result = dec ? post : (post ^ key);
   end

endmodule

@@ rtl/spn_block_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// spn_block_cipher_unit
// Keyed substitution-permutation cipher on 16-byte blocks.
// ----------------------------------------------------------------------------
// req channel: tuser carries the operation; tdata carries index, value and the
// block. Load operations write the s-box (and its inverse), the nibble p-box
// (and its inverse) or one round-key byte and give no rsp transfer. Encrypt and
// decrypt give one rsp transfer with the processed block.
// Sixteen byte lanes each own an s-box, inverse s-box and key copy and run one
// round per cycle; a shared merge stage permutes or diffuses across lanes.
// After its req transfer a block runs through its rounds in the RUN state (one
// round per cycle, bound by the s-box read feeding back into the state
// register), then waits in FIN until its result moves into the output register;
// the next req transfer is taken once the engine is back in IDLE.
// Only one block is in flight; req_tready is high when the round engine is
// free, also while an earlier result still waits on rsp.
// Reset returns the registers to 16 rounds and a p-box period of 2 and clears
// the control state; table contents are undefined until loaded.
// When rsp_tready is low the result is held and a finished block waits in the
// engine until the output register frees up.
// ----------------------------------------------------------------------------
module spn_block_cipher_unit
   import sbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,  // operation
   input  logic [143:0] req_tdata,  // index, value, block_hi, block_lo
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_hi, result_lo
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [4:0]   csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [4:0]     round_count_ff, pbox_period_ff;
   logic [3:0]     round_ff, round_in;
   logic           dec_ff, dec_in;
   logic           first_ff, first_in;
   byte_array_type blk_ff, blk_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [127:0]   rsp_data_ff, rsp_data_in;
   nib_sel_type    pbox_ff, rev_pbox_ff;

   logic [4:0]     rounds_eff, period_eff, rnum;
   logic [3:0]     last_round;
   logic [MaxRounds:0] perm_mask;
   logic [8:0]     prod;
   logic           accept, is_crypt, do_perm, do_diff, round_last, out_free;
   byte_array_type in_blk, sub_bytes, key_bytes, mix_src, mix_out;
   logic [NumBytes-1:0] key_we;
   lane_wr_type    lane_wr;
   logic [127:0]   fin_data;

   assign accept   = req_tvalid && req_tready;
   assign is_crypt = (req_tuser == OP_ENCRYPT) || (req_tuser == OP_DECRYPT);
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // byte 0 is the top byte of block_hi, byte 8 the top byte of block_lo
   always_comb begin
      for (int k = 0; k < NumBytes/2; k++) begin
         in_blk[k]              = req_tdata[79 - 8*k -: 8];
         in_blk[k + NumBytes/2] = req_tdata[143 - 8*k -: 8];
      end
   end

   assign rounds_eff = (round_count_ff == 5'd0) ? 5'd1 :
                       (round_count_ff > 5'(MaxRounds)) ? 5'(MaxRounds) : round_count_ff;
   assign period_eff = (pbox_period_ff == 5'd0) ? 5'd1 : pbox_period_ff;
   assign last_round = 4'(rounds_eff - 5'd1);

   // round r is a multiple of the period when period*q == r for some q
   always_comb begin
      perm_mask = '0;
      prod      = '0;
      for (int r = 1; r <= MaxRounds; r++) begin
         for (int q = 1; q <= MaxRounds; q++) begin
            prod = {4'd0, period_eff} * 9'(q);
            if (prod == 9'(r)) begin
               perm_mask[r] = 1'b1;
            end
         end
      end
   end

   assign rnum    = {1'b0, round_ff} + 5'd1;
   assign do_perm = perm_mask[rnum] && (rnum[1:0] != 2'd0);
   assign do_diff = (rnum[1:0] == 2'd0);
   assign round_last = dec_ff ? (round_ff == 4'd0) : (round_ff == last_round);

   // table writes
   assign lane_wr.sbox_we = accept && (req_tuser == OP_LOAD_SBOX);
   assign lane_wr.index   = req_tdata[7:0];
   assign lane_wr.value   = req_tdata[15:8];

   always_comb begin
      for (int k = 0; k < NumBytes; k++) begin
         key_we[k] = accept && (req_tuser == OP_LOAD_KEY) &&
                     (req_tdata[3:0] == 4'(k));
      end
   end

   for (genvar gk = 0; gk < NumBytes; gk++) begin : g_lane
      sbc_lane u_lane (
         .clock      (clock),
         .wr         (lane_wr),
         .key_we     (key_we[gk]),
         .byte_addr  (blk_in[gk]),
         .round_addr (round_in),
         .dec        (dec_ff),
         .sub_byte   (sub_bytes[gk]),
         .key_byte   (key_bytes[gk])
      );
   end

   // decrypt starts with the key xor on the raw block
   assign mix_src = (dec_ff && first_ff) ? blk_ff : sub_bytes;

   sbc_mix u_mix (
      .data     (mix_src),
      .key      (key_bytes),
      .pbox     (pbox_ff),
      .rev_pbox (rev_pbox_ff),
      .dec      (dec_ff),
      .do_perm  (do_perm),
      .do_diff  (do_diff),
      .result   (mix_out)
   );

   always_comb begin
      for (int k = 0; k < NumBytes/2; k++) begin
         fin_data[63 - 8*k -: 8]  = dec_ff ? sub_bytes[k] : blk_ff[k];
         fin_data[127 - 8*k -: 8] = dec_ff ? sub_bytes[k + NumBytes/2] :
                                             blk_ff[k + NumBytes/2];
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      dec_in       = dec_ff;
      first_in     = first_ff;
      blk_in       = blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_crypt) begin
               dec_in   = (req_tuser == OP_DECRYPT);
               round_in = (req_tuser == OP_DECRYPT) ? last_round : 4'd0;
               blk_in   = in_blk;
               first_in = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            blk_in   = mix_out;
            first_in = 1'b0;
            if (round_last) begin
               state_in = ST_FIN;
            end else begin
               round_in = dec_ff ? (round_ff - 4'd1) : (round_ff + 4'd1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fin_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         round_count_ff <= 5'd16;
         pbox_period_ff <= 5'd2;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_ROUND_COUNT)) begin
            round_count_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_PBOX_PERIOD)) begin
            pbox_period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      round_ff    <= round_in;
      dec_ff      <= dec_in;
      first_ff    <= first_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
      if (accept && (req_tuser == OP_LOAD_PBOX) &&
          (req_tdata[7:5] == 3'd0) && (req_tdata[15:13] == 3'd0)) begin
         pbox_ff[req_tdata[4:0]]      <= req_tdata[12:8];
         rev_pbox_ff[req_tdata[12:8]] <= req_tdata[4:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spn_block_cipher_unit: loads permutation tables and
// round keys, walks a directed table, then runs random cipher traffic under
// several round and p-box settings with random idling and back-pressure,
// checking every rsp transfer against a typed or a bit-exact predicted block.
// ----------------------------------------------------------------------------
module testbench;
   import sbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] octet_type;

   typedef struct {
      logic [2:0]  op;
      logic [7:0]  idx;
      logic [7:0]  val;
      logic [63:0] hi;
      logic [63:0] lo;
      bit          known;
      logic [63:0] exp_hi;
      logic [63:0] exp_lo;
   } stim_row_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [2:0]   req_tuser = OP_LOAD_KEY;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_ROUND_COUNT;
   logic [4:0]   csr_wdata = '0;

   spn_block_cipher_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor state
   octet_type  sub_tab[256], inv_sub_tab[256], key_tab[256];
   logic [4:0] perm_tab[32], inv_perm_tab[32];
   logic [4:0] cfg_rounds = 5'd16;
   logic [4:0] cfg_period = 5'd2;
   octet_type  blk[16];
   block_type  pending_blocks[$];

   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  stall_requests = 0;
   int  stalls_taken = 0;
   bit  typed_valid = 0;
   logic [63:0] typed_hi, typed_lo;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic void mix_nibbles(input bit use_forward_sel);
      logic [3:0] nin[32];
      logic [3:0] nout[32];
      for (int k = 0; k < 16; k++) begin
         nin[2*k]   = blk[k][7:4];
         nin[2*k+1] = blk[k][3:0];
      end
      for (int j = 0; j < 32; j++)
         nout[j] = nin[use_forward_sel ? perm_tab[j] : inv_perm_tab[j]];
      for (int k = 0; k < 16; k++)
         blk[k] = {nout[2*k], nout[2*k+1]};
   endfunction

   function automatic void add_round_key(input int r);
      for (int k = 0; k < 16; k++)
         blk[k] ^= key_tab[((r - 1) * 16 + k) & 255];
   endfunction

   function automatic block_type cipher_block(input bit decrypt, input logic [63:0] hi,
                                              input logic [63:0] lo);
      block_type res;
      int rounds, per;
      rounds = (cfg_rounds == 0) ? 1 : (cfg_rounds > MaxRounds ? MaxRounds : cfg_rounds);
      per = (cfg_period == 0) ? 1 : cfg_period;
      for (int k = 0; k < 8; k++) begin
         blk[k]   = hi[63-8*k -: 8];
         blk[k+8] = lo[63-8*k -: 8];
      end
      if (!decrypt) begin
         for (int r = 1; r <= rounds; r++) begin
            for (int k = 0; k < 16; k++) blk[k] = sub_tab[blk[k]];
            if (r % per == 0 && r % 4 != 0) mix_nibbles(1'b0);
            else if (r % 4 == 0) begin
               for (int k = 0; k < 15; k++) blk[k+1] ^= blk[k];
               blk[0] ^= blk[15];
            end
            add_round_key(r);
         end
      end else begin
         for (int r = rounds; r >= 1; r--) begin
            add_round_key(r);
            if (r % per == 0 && r % 4 != 0) mix_nibbles(1'b1);
            else if (r % 4 == 0) begin
               blk[0] ^= blk[15];
               for (int k = 15; k > 0; k--) blk[k] ^= blk[k-1];
            end
            for (int k = 0; k < 16; k++) blk[k] = inv_sub_tab[blk[k]];
         end
      end
      for (int k = 0; k < 8; k++) begin
         res.hi[63-8*k -: 8] = blk[k];
         res.lo[63-8*k -: 8] = blk[k+8];
      end
      return res;
   endfunction

   // transfer monitor: update tables, queue expected blocks, check results
   always @(posedge clock) begin
      logic [7:0] idx, val;
      block_type exp_blk;
      if (!reset && req_tvalid && req_tready) begin
         idx = req_tdata[7:0];
         val = req_tdata[15:8];
         case (req_tuser)
            OP_LOAD_SBOX: begin
               sub_tab[idx] = val;
               inv_sub_tab[val] = idx;
            end
            OP_LOAD_PBOX: begin
               if (idx < NumNibbles && val < NumNibbles) begin
                  perm_tab[idx[4:0]] = val[4:0];
                  inv_perm_tab[val[4:0]] = idx[4:0];
               end
            end
            OP_LOAD_KEY: key_tab[idx] = val;
            OP_ENCRYPT, OP_DECRYPT: begin
               exp_blk = cipher_block(req_tuser == OP_DECRYPT,
                                      req_tdata[79:16], req_tdata[143:80]);
               if (typed_valid) begin
                  exp_blk.hi = typed_hi;
                  exp_blk.lo = typed_lo;
               end
               pending_blocks.push_back(exp_blk);
            end
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_blocks.size() == 0) begin
            report_mismatch("unexpected rsp transfer", rsp_tdata[63:0], 64'h0);
         end else begin
            exp_blk = pending_blocks.pop_front();
            if (rsp_tdata[63:0] !== exp_blk.hi)
               report_mismatch("result_hi", rsp_tdata[63:0], exp_blk.hi);
            if (rsp_tdata[127:64] !== exp_blk.lo)
               report_mismatch("result_lo", rsp_tdata[127:64], exp_blk.lo);
         end
      end
   end

   // receiver: random stalls plus requested long hold-offs
   always @(negedge clock) begin
      int hold;
      if (stall_requests != stalls_taken) begin
         stalls_taken = stall_requests;
         hold = 300;
      end
      if (hold > 0) begin
         hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [7:0] idx,
                            input logic [7:0] val, input logic [63:0] hi,
                            input logic [63:0] lo);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {lo, hi, val, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic which, input logic [4:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (which == CSR_ROUND_COUNT) cfg_rounds = data;
      else cfg_period = data;
   endtask

   task automatic load_tables(input bit identity);
      octet_type  sperm[256];
      logic [4:0] pperm[32];
      octet_type  t8;
      logic [4:0] t5;
      int         j;
      for (int i = 0; i < 256; i++) sperm[i] = 8'(i);
      for (int i = 0; i < 32; i++) pperm[i] = 5'(i);
      if (!identity) begin
         for (int i = 255; i > 0; i--) begin
            j = $urandom_range(i);
            t8 = sperm[i]; sperm[i] = sperm[j]; sperm[j] = t8;
         end
         for (int i = 31; i > 0; i--) begin
            j = $urandom_range(i);
            t5 = pperm[i]; pperm[i] = pperm[j]; pperm[j] = t5;
         end
      end
      for (int i = 0; i < 256; i++) send_item(OP_LOAD_SBOX, 8'(i), sperm[i], '0, '0);
      for (int i = 0; i < 32; i++)
         send_item(OP_LOAD_PBOX, 8'(i), {3'b0, pperm[i]}, '0, '0);
      for (int i = 0; i < 256; i++)
         send_item(OP_LOAD_KEY, 8'(i), identity ? 8'h00 : 8'($urandom), '0, '0);
   endtask

   task automatic random_item();
      int pick;
      logic [63:0] hi, lo;
      pick = $urandom_range(99);
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      if (pick < 38)      send_item(OP_ENCRYPT, 8'($urandom), 8'($urandom), hi, lo);
      else if (pick < 76) send_item(OP_DECRYPT, 8'($urandom), 8'($urandom), hi, lo);
      else if (pick < 86) send_item(OP_LOAD_KEY, 8'($urandom), 8'($urandom), hi, lo);
      else if (pick < 91) send_item(OP_LOAD_SBOX, 8'($urandom), 8'($urandom), hi, lo);
      else if (pick < 96)
         send_item(OP_LOAD_PBOX, 8'($urandom_range(63)), 8'($urandom_range(63)), hi, lo);
      else send_item(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), hi, lo);
   endtask

   stim_row_type directed[$];
   logic [4:0] phase_rounds[9] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd7, 5'd12, 5'd2};
   logic [4:0] phase_period[9] = '{5'd2, 5'd1, 5'd0, 5'd31, 5'd3, 5'd1, 5'd16, 5'd5, 5'd2};

   initial begin
      localparam logic [63:0] ONES = '1;
      // identity tables with zero keys leave a zero block at zero
      directed = '{
         '{OP_ENCRYPT, 8'h00, 8'h00, 64'h0, 64'h0, 1, 64'h0, 64'h0},
         '{OP_DECRYPT, 8'h00, 8'h00, 64'h0, 64'h0, 1, 64'h0, 64'h0},
         '{3'd5, 8'hff, 8'hff, ONES, ONES, 0, 64'h0, 64'h0},
         '{3'd6, 8'h00, 8'h00, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{3'd7, 8'hff, 8'hff, ONES, ONES, 0, 64'h0, 64'h0},
         '{OP_LOAD_PBOX, 8'd32, 8'd0, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_LOAD_PBOX, 8'd0, 8'd32, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_LOAD_PBOX, 8'hff, 8'hff, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_ENCRYPT, 8'hff, 8'hff, ONES, ONES, 0, 64'h0, 64'h0},
         '{OP_DECRYPT, 8'hff, 8'hff, ONES, ONES, 0, 64'h0, 64'h0},
         '{OP_LOAD_KEY, 8'hff, 8'hff, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_LOAD_KEY, 8'h00, 8'ha5, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_ENCRYPT, 8'h00, 8'h00, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_DECRYPT, 8'h00, 8'h00, ONES, ONES, 0, 64'h0, 64'h0},
         '{OP_LOAD_SBOX, 8'h00, 8'hff, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_LOAD_PBOX, 8'd0, 8'd1, 64'h0, 64'h0, 0, 64'h0, 64'h0},
         '{OP_ENCRYPT, 8'h00, 8'h00, 64'h0123456789abcdef, ONES, 0, 64'h0, 64'h0},
         '{OP_DECRYPT, 8'h00, 8'h00, 64'hfedcba9876543210, 64'h0, 0, 64'h0, 64'h0}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_tables(1'b1);
      foreach (directed[i]) begin
         // move the typed expectation away from the previous accepting edge
         @(negedge clock);
         typed_valid = directed[i].known;
         typed_hi = directed[i].exp_hi;
         typed_lo = directed[i].exp_lo;
         send_item(directed[i].op, directed[i].idx, directed[i].val,
                   directed[i].hi, directed[i].lo);
      end
      quiesce();
      typed_valid = 0;

      for (int p = 0; p < 9; p++) begin
         send_idle_pct = (p < 3) ? 21 : (p < 6) ? 47 : 0;
         recv_idle_pct = (p < 3) ? 47 : (p < 6) ? 21 : 0;
         csr_write(CSR_ROUND_COUNT, phase_rounds[p]);
         csr_write(CSR_PBOX_PERIOD, phase_period[p]);
         if (p == 0) load_tables(1'b0);
         for (int n = 0; n < 90; n++) begin
            if (n == 30) stall_requests++;
            // sender pause until the engine has drained
            if (n == 60) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               while (pending_blocks.size() != 0) @(posedge clock);
            end
            random_item();
         end
         quiesce();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/sbc_pkg.sv
rtl/sbc_ram.sv
rtl/sbc_lane.sv
rtl/sbc_mix.sv
rtl/spn_block_cipher_unit.sv
tb/sv/testbench.sv
